@@ rtl/jsu_pkg.sv @@
package jsu_pkg;

  localparam int CP_W = 21;

  typedef enum logic {
    TK_RAW,
    TK_UTF
  } tok_kind_t;

  // one decided unit of output: a raw byte or a code point to be utf-8 encoded
  typedef struct packed {
    tok_kind_t         kind;
    logic [CP_W-1:0]   cp;
    logic              last;
  } tok_t;

endpackage

@@ rtl/jsu_front.sv @@
module jsu_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  input  logic          q_full,
  output logic          q_push,
  output jsu_pkg::tok_t q_tok
);
  import jsu_pkg::*;

  localparam int WIN   = 12;
  localparam int CNT_W = $clog2(WIN + 1);
  localparam int IDX_W = $clog2(WIN);

  localparam logic [7:0] CH_BS = 8'h5C;
  localparam logic [7:0] CH_U  = 8'h75;
  localparam logic [7:0] CH_B  = 8'h62;
  localparam logic [7:0] CH_F  = 8'h66;
  localparam logic [7:0] CH_N  = 8'h6E;
  localparam logic [7:0] CH_R  = 8'h72;
  localparam logic [7:0] CH_T  = 8'h74;

  typedef logic [WIN-1:0][7:0] win_t;

  win_t             win_r, win_nxt, win_sh;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_sh, cnt_base, used;
  logic             lst_r, lst_nxt;
  logic             blocked_now, blocked_sh, res_go, in_fire, pair;
  logic [15:0]      hi_unit, lo_unit;
  tok_t             tok;

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [3:0] v;
    v = 4'h0;
    if (c inside {[8'h30:8'h39]}) begin
      v = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      v = c[3:0] + 4'd9;
    end
    return v;
  endfunction

  function automatic logic [7:0] esc_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      CH_B:    v = 8'h08;
      CH_F:    v = 8'h0C;
      CH_N:    v = 8'h0A;
      CH_R:    v = 8'h0D;
      CH_T:    v = 8'h09;
      default: v = c;
    endcase
    return v;
  endfunction

  // head of the window still needs more bytes before it can be decided
  function automatic logic is_blocked(input win_t w, input logic [CNT_W-1:0] c,
                                      input logic l);
    return (c == '0) ||
           (!l && w[0] == CH_BS &&
            (c < CNT_W'(2) || (w[1] == CH_U && c < CNT_W'(WIN))));
  endfunction

  always_comb begin
    hi_unit = {hex_val(win_r[2]), hex_val(win_r[3]), hex_val(win_r[4]), hex_val(win_r[5])};
    lo_unit = {hex_val(win_r[8]), hex_val(win_r[9]), hex_val(win_r[10]),
               hex_val(win_r[11])};
    pair = (cnt_r == CNT_W'(WIN)) &&
           (win_r[2] inside {8'h44, 8'h64}) &&
           (win_r[3] inside {8'h38, 8'h39, 8'h41, 8'h61, 8'h42, 8'h62}) &&
           (win_r[6] == CH_BS) && (win_r[7] == CH_U) &&
           (win_r[8] inside {8'h44, 8'h64}) &&
           (win_r[9] inside {[8'h43:8'h46], [8'h63:8'h66]});

    tok      = '0;
    tok.kind = TK_RAW;
    used     = CNT_W'(1);
    if (win_r[0] != CH_BS) begin
      tok.cp = CP_W'(win_r[0]);
    end else if (cnt_r < CNT_W'(2)) begin
      tok.cp = CP_W'(CH_BS);
    end else if (win_r[1] != CH_U) begin
      tok.cp = CP_W'(esc_map(win_r[1]));
      used   = CNT_W'(2);
    end else if (cnt_r < CNT_W'(6)) begin
      tok.cp = CP_W'(CH_U);
      used   = CNT_W'(2);
    end else if (pair) begin
      tok.kind = TK_UTF;
      tok.cp   = CP_W'(17'h10000) + CP_W'({hi_unit[9:0], lo_unit[9:0]});
      used     = CNT_W'(WIN);
    end else begin
      tok.kind = TK_UTF;
      tok.cp   = CP_W'(hi_unit);
      used     = CNT_W'(6);
    end

    cnt_sh   = cnt_r - used;
    win_sh   = win_r >> {used, 3'b000};
    tok.last = lst_r && (cnt_sh == '0);

    blocked_now = is_blocked(win_r, cnt_r, lst_r);
    blocked_sh  = is_blocked(win_sh, cnt_sh, lst_r);
    res_go      = !blocked_now && !q_full;
    in_tready   = blocked_now || (res_go && blocked_sh);
    in_fire     = in_tvalid && in_tready;

    q_push = res_go;
    q_tok  = tok;

    win_nxt  = res_go ? win_sh : win_r;
    cnt_base = res_go ? cnt_sh : cnt_r;
    if (in_fire) begin
      win_nxt[cnt_base[IDX_W-1:0]] = in_tdata;
    end
    cnt_nxt = cnt_base + CNT_W'(in_fire);

    if (in_fire) begin
      lst_nxt = in_tlast;
    end else if (res_go && cnt_sh == '0) begin
      lst_nxt = 1'b0;
    end else begin
      lst_nxt = lst_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      lst_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      lst_r <= lst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  a_win_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WIN))
    else $error("window count beyond depth");

  a_last_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    lst_r |-> cnt_r != '0)
    else $error("end of string marked on empty window");

  a_accept_after_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && lst_r) |-> (res_go && cnt_sh == '0))
    else $error("new word taken before string flushed");

endmodule

@@ rtl/jsu_queue.sv @@
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jsu_pkg::tok_t push_tok,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output jsu_pkg::tok_t pop_tok
);
  import jsu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem_r [DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    full      = (count_r == CW'(DEPTH));
    not_empty = (count_r != '0);
    pop_tok   = mem_r[rd_r];
    wr_nxt    = wr_r;
    rd_nxt    = rd_r;
    if (push) begin
      wr_nxt = (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
    end
    if (pop) begin
      rd_nxt = (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_tok;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue overflow");

endmodule

@@ rtl/jsu_back.sv @@
module jsu_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  jsu_pkg::tok_t q_tok,
  output logic          q_pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [7:0]    out_tdata,
  output logic          out_tlast
);
  import jsu_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic [1:0] k_r, k_nxt;
  logic [1:0] n_m1, rem;
  logic       load, final_byte;
  logic [7:0] lead, cont, cur;

  always_comb begin
    if (q_tok.kind == TK_RAW || q_tok.cp <= CP_W'(16'h007F)) begin
      n_m1 = 2'd0;
    end else if (q_tok.cp <= CP_W'(16'h07FF)) begin
      n_m1 = 2'd1;
    end else if (q_tok.cp <= CP_W'(16'hFFFF)) begin
      n_m1 = 2'd2;
    end else begin
      n_m1 = 2'd3;
    end
    rem        = n_m1 - k_r;
    final_byte = (k_r == n_m1);

    case (n_m1)
      2'd0:    lead = (q_tok.kind == TK_RAW) ? q_tok.cp[7:0] : {1'b0, q_tok.cp[6:0]};
      2'd1:    lead = 8'hC0 | {3'b000, q_tok.cp[10:6]};
      2'd2:    lead = 8'hE0 | {4'b0000, q_tok.cp[15:12]};
      default: lead = 8'hF0 | {5'b00000, q_tok.cp[20:18]};
    endcase

    case (rem)
      2'd0:    cont = {2'b10, q_tok.cp[5:0]};
      2'd1:    cont = {2'b10, q_tok.cp[11:6]};
      default: cont = {2'b10, q_tok.cp[17:12]};
    endcase

    cur   = (k_r == 2'd0) ? lead : cont;
    load  = q_valid && (!out_valid_r || out_tready);
    q_pop = load && final_byte;

    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    k_nxt         = k_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur;
      out_last_nxt  = q_tok.last && final_byte;
      k_nxt         = final_byte ? 2'd0 : k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      k_r         <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

  a_mid_token_held: assert property (@(posedge clk) disable iff (!rst_n)
    k_r != 2'd0 |-> q_valid)
    else $error("partly sent code point left the queue");

endmodule

@@ rtl/json_string_unescape_utf8.sv @@
// channel | dir | tdata            | tlast                | tuser
// in_     | in  | [7:0] raw byte   | final byte of string | -
// out_    | out | [7:0] utf-8 byte | final byte of string | -
//
// plain bytes flow at one word per cycle unless out_ stalls; a decided escape becomes one queue token
// \u escapes expand to 1 to 4 output bytes, one per cycle from the encoder while out_ is ready
// a failed pair lookahead rescans the bytes behind the first \uXXXX from the window
// reset: synchronous rst_n clears window count, queue pointers and output valid
// out_ stalls fill the queue, then the front and in_tready hold
module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast
);
  import jsu_pkg::*;

  tok_t push_tok, pop_tok;
  logic push, pop, full, not_empty;

  jsu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (full),
    .q_push    (push),
    .q_tok     (push_tok)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (push_tok),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_tok   (pop_tok)
  );

  jsu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (not_empty),
    .q_tok      (pop_tok),
    .q_pop      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

@@ dv/json_string_unescape_utf8_test.sv @@
module json_string_unescape_utf8_test;

  localparam int          LIMIT_CYCLES = 200000;
  localparam int          TARGET_ITEMS = 410;
  localparam int          DRAIN_CYCLES = 40;
  localparam int          WIN_DEPTH    = 12;
  localparam int          PEND_DEPTH   = 11;
  localparam logic [7:0]  CH_BSLASH    = 8'h5C;
  localparam logic [7:0]  CH_U         = "u";
  localparam logic [7:0]  CH_B         = "b";
  localparam logic [7:0]  CH_F         = "f";
  localparam logic [7:0]  CH_N         = "n";
  localparam logic [7:0]  CH_R         = "r";
  localparam logic [7:0]  CH_T         = "t";
  localparam logic [7:0]  CTL_BS       = 8'h08;
  localparam logic [7:0]  CTL_FF       = 8'h0C;
  localparam logic [7:0]  CTL_LF       = 8'h0A;
  localparam logic [7:0]  CTL_CR       = 8'h0D;
  localparam logic [7:0]  CTL_TAB      = 8'h09;
  localparam logic [15:0] HIGH_SURR    = 16'hD800;
  localparam logic [15:0] LOW_SURR     = 16'hDC00;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_word_t;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;

  // handshake state sampled mid-cycle, used at the following rising edge
  logic       in_fire_s;
  logic [7:0] in_byte_s;
  logic       in_last_s;
  logic       out_fire_s;
  logic [7:0] out_byte_s;
  logic       out_last_s;

  // unescaper state mirror
  logic [7:0] pend_bytes [PEND_DEPTH];
  int         pend_cnt;
  logic [7:0] scan_win [WIN_DEPTH];
  logic [7:0] step_bytes [$];
  out_word_t  utf8_expected [$];

  logic [7:0] str_q [$];
  int         error_count;
  int         sent_items;
  int         cycle_count;
  int         tx_idle_pct;
  int         rx_idle_pct;
  int         hold_cycles;

  json_string_unescape_utf8 dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("%0t: timeout with %0d words still expected", $time, utf8_expected.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    in_fire_s  = rst_n && in_tvalid && in_tready;
    in_byte_s  = in_tdata;
    in_last_s  = in_tlast;
    out_fire_s = rst_n && out_tvalid && out_tready;
    out_byte_s = out_tdata;
    out_last_s = out_tlast;
  end

  // receiver: random stalls, plus a long hold-off counted here
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (rx_idle_pct == 0) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return 4'(c - "0");
    if (c >= "A" && c <= "F") return 4'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 4'(c - "a" + 10);
    return 4'd0;
  endfunction

  function automatic logic [15:0] hex_quad(input int base);
    return {hex_nibble(scan_win[base]), hex_nibble(scan_win[base + 1]),
            hex_nibble(scan_win[base + 2]), hex_nibble(scan_win[base + 3])};
  endfunction

  function automatic bit pair_ahead();
    logic [7:0] a, b, c, d;
    a = scan_win[2];
    b = scan_win[3];
    c = scan_win[8];
    d = scan_win[9];
    if (!(a == "d" || a == "D")) return 1'b0;
    if (!(b == "8" || b == "9" || b == "A" || b == "a" || b == "B" || b == "b")) return 1'b0;
    if (scan_win[6] != CH_BSLASH || scan_win[7] != CH_U) return 1'b0;
    if (!(c == "d" || c == "D")) return 1'b0;
    return (d >= "C" && d <= "F") || (d >= "c" && d <= "f");
  endfunction

  function automatic logic [7:0] short_escape(input logic [7:0] c);
    case (c)
      CH_B:    return CTL_BS;
      CH_F:    return CTL_FF;
      CH_N:    return CTL_LF;
      CH_R:    return CTL_CR;
      CH_T:    return CTL_TAB;
      default: return c;
    endcase
  endfunction

  function automatic void emit_code_point(input logic [20:0] cp);
    if (cp <= 21'h7F) begin
      step_bytes.push_back(cp[7:0]);
    end else if (cp <= 21'h7FF) begin
      step_bytes.push_back(8'hC0 + 8'(cp >> 6));
      step_bytes.push_back(8'h80 + 8'(cp & 21'h3F));
    end else if (cp <= 21'hFFFF) begin
      step_bytes.push_back(8'hE0 + 8'(cp >> 12));
      step_bytes.push_back(8'h80 + 8'((cp >> 6) & 21'h3F));
      step_bytes.push_back(8'h80 + 8'(cp & 21'h3F));
    end else begin
      step_bytes.push_back(8'hF0 + 8'(cp >> 18));
      step_bytes.push_back(8'h80 + 8'((cp >> 12) & 21'h3F));
      step_bytes.push_back(8'h80 + 8'((cp >> 6) & 21'h3F));
      step_bytes.push_back(8'h80 + 8'(cp & 21'h3F));
    end
  endfunction

  function automatic void unescape_step(input logic [7:0] nb, input logic lst);
    int          cnt;
    int          used;
    logic [15:0] hi;
    logic [15:0] lo;
    out_word_t   w;
    step_bytes.delete();
    for (int i = 0; i < PEND_DEPTH; i++) scan_win[i] = pend_bytes[i];
    cnt = pend_cnt;
    scan_win[cnt] = nb;
    cnt++;
    while (cnt > 0) begin
      used = 0;
      if (scan_win[0] != CH_BSLASH) begin
        step_bytes.push_back(scan_win[0]);
        used = 1;
      end else if (cnt < 2) begin
        if (lst) begin
          step_bytes.push_back(CH_BSLASH);
          used = 1;
        end
      end else if (scan_win[1] != CH_U) begin
        step_bytes.push_back(short_escape(scan_win[1]));
        used = 2;
      end else if (cnt < 6) begin
        if (lst) begin
          step_bytes.push_back(CH_U);
          used = 2;
        end
      end else if (cnt < WIN_DEPTH && !lst) begin
        used = 0;
      end else if (cnt >= WIN_DEPTH && pair_ahead()) begin
        hi = (hex_quad(2) - HIGH_SURR) & 16'h3FF;
        lo = (hex_quad(8) - LOW_SURR) & 16'h3FF;
        emit_code_point(21'h10000 + {1'b0, hi[9:0], lo[9:0]});
        used = 12;
      end else begin
        emit_code_point({5'd0, hex_quad(2)});
        used = 6;
      end
      if (used == 0) break;
      for (int i = 0; i + used < WIN_DEPTH; i++) scan_win[i] = scan_win[i + used];
      cnt -= used;
    end
    if (lst) cnt = 0;
    for (int i = 0; i < cnt; i++) pend_bytes[i] = scan_win[i];
    pend_cnt = cnt;
    for (int i = 0; i < step_bytes.size(); i++) begin
      w.data = step_bytes[i];
      w.last = lst && (i == step_bytes.size() - 1);
      utf8_expected.push_back(w);
    end
  endfunction

  function automatic void check_word(input logic [7:0] b, input logic lst);
    out_word_t w;
    if (utf8_expected.size() == 0) begin
      error_count++;
      $display("%0t: unexpected word, expected none, actual %02h last %0b", $time, b, lst);
      return;
    end
    w = utf8_expected.pop_front();
    if (w.data !== b || w.last !== lst) begin
      error_count++;
      $display("%0t: mismatch, expected %02h last %0b, actual %02h last %0b",
               $time, w.data, w.last, b, lst);
    end
  endfunction

  // scoreboard: predict on each accepted input word, check each output word
  always @(posedge clk) begin
    if (in_fire_s) unescape_step(in_byte_s, in_last_s);
    if (out_fire_s) check_word(out_byte_s, out_last_s);
  end

  task automatic send_byte(input logic [7:0] b, input logic lst);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_fire_s);
    sent_items++;
  endtask

  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (utf8_expected.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  task automatic add_hex_digit(input logic [3:0] d);
    if ($urandom_range(15) == 0)
      str_q.push_back(8'($urandom_range(255)));
    else if (d < 10)
      str_q.push_back("0" + 8'(d));
    else if ($urandom_range(1))
      str_q.push_back("a" + 8'(d - 10));
    else
      str_q.push_back("A" + 8'(d - 10));
  endtask

  task automatic add_unit(input logic [15:0] v);
    str_q.push_back(CH_BSLASH);
    str_q.push_back(CH_U);
    add_hex_digit(v[15:12]);
    add_hex_digit(v[11:8]);
    add_hex_digit(v[7:4]);
    add_hex_digit(v[3:0]);
  endtask

  task automatic add_token();
    logic [7:0]  esc_set [8];
    logic [15:0] v;
    esc_set = '{CH_B, CH_F, CH_N, CH_R, CH_T, "\"", CH_BSLASH, "/"};
    case ($urandom_range(11))
      0, 1: str_q.push_back(8'($urandom_range(255)));
      2: str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
      3, 4: begin
        str_q.push_back(CH_BSLASH);
        if ($urandom_range(3) == 0) str_q.push_back(8'($urandom_range(255)));
        else str_q.push_back(esc_set[$urandom_range(7)]);
      end
      5, 6: begin
        case ($urandom_range(3))
          0: v = 16'($urandom_range(16'h7F));
          1: v = 16'($urandom_range(16'h80, 16'h7FF));
          2: v = 16'($urandom_range(16'h800, 16'hFFFF));
          default: v = 16'($urandom_range(16'hD800, 16'hDFFF));
        endcase
        add_unit(v);
      end
      7, 8, 9: begin
        add_unit(HIGH_SURR + 16'($urandom_range(16'h3FF)));
        case ($urandom_range(5))
          0: add_unit(16'($urandom_range(16'hFFFF)));
          1: begin
            str_q.push_back(8'($urandom_range(255)));
            add_unit(LOW_SURR + 16'($urandom_range(16'h3FF)));
          end
          default: add_unit(LOW_SURR + 16'($urandom_range(16'h3FF)));
        endcase
      end
      10: begin
        str_q.push_back(CH_BSLASH);
        str_q.push_back(CH_U);
        repeat ($urandom_range(3)) add_hex_digit(4'($urandom_range(15)));
      end
      default: str_q.push_back(CH_BSLASH);
    endcase
  endtask

  task automatic add_random_string(input int max_tokens);
    repeat ($urandom_range(1, max_tokens)) add_token();
    // cut strings short so escapes end early
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 5)) if (str_q.size() > 1) void'(str_q.pop_back());
  endtask

  task automatic test_directed();
    add_text("\\uD83D\\uDE00");
    send_string();
    add_text("\\b\\f\\n\\r\\t\\q");
    send_string();
    add_text("\\u7");
    send_string();
    str_q.push_back(8'h00);
    str_q.push_back(8'hFF);
    str_q.push_back(CH_BSLASH);
    send_string();
    wait_drained();
  endtask

  task automatic test_backpressure();
    int start_items;
    start_items = sent_items;
    tx_idle_pct = 0;
    hold_cycles = 400;
    while (sent_items - start_items < 40) begin
      add_random_string(6);
      send_string();
    end
    tx_idle_pct = 29;
    wait_drained();
  endtask

  task automatic test_no_idle();
    int start_items;
    start_items = sent_items;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (sent_items - start_items < 60) begin
      add_random_string(8);
      send_string();
    end
    tx_idle_pct = 29;
    rx_idle_pct = 29;
    wait_drained();
  endtask

  task automatic test_random();
    while (sent_items < TARGET_ITEMS) begin
      add_random_string($urandom_range(3) == 0 ? 12 : 5);
      send_string();
      if ($urandom_range(15) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= 8'h00;
    in_tlast    <= 1'b0;
    error_count = 0;
    sent_items  = 0;
    pend_cnt    = 0;
    tx_idle_pct = 29;
    rx_idle_pct = 29;
    hold_cycles = 0;
    for (int i = 0; i < PEND_DEPTH; i++) pend_bytes[i] = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_no_idle();
    test_random();
    if (error_count == 0 && utf8_expected.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
